### hw/rtl/bfpa_pkg.sv
// Shared types, constants and sequencer states of the best-fit pool allocator.
// Depends on nothing; the top level takes everything here by scoped names.
`timescale 1ns / 1ps

package bfpa_pkg;

  // Pool geometry
  localparam int unsigned POOL_DEPTH = 4096;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned TAG_W      = 14;
  localparam int unsigned NPOOL_W    = 13;
  localparam logic [NPOOL_W-1:0] MIN_POOL   = 13'd128;
  localparam logic [NPOOL_W-1:0] MAX_POOL   = 13'd4096;
  localparam logic [ADDR_W-1:0]  FIRST_BLK  = 12'd2;
  localparam int signed          OVERHEAD   = 4;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT     = 2'd1;
  localparam logic [1:0] STATUS_BAD_HANDLE = 2'd2;

  // Signed working value: tags, sizes, pool indexes and sums of two sizes
  typedef logic signed [15:0] word_t;

  typedef struct packed {
    logic                   cmd;
    logic [NPOOL_W-1:0]     request_words;
    logic [ADDR_W-1:0]      handle;
  } in_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [ADDR_W-1:0]      address;
    logic                   all_free;
  } out_t;

  typedef enum logic [5:0] {
    ST_INIT0, ST_INIT1, ST_INIT2, ST_INIT3, ST_IDLE,
    ST_A0, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5, ST_A5B, ST_A6, ST_A7, ST_A8, ST_A9,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_F8, ST_F9,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
    ST_FIN0, ST_FIN1,
    ST_FF0, ST_FF_CHK, ST_FF_SZ, ST_FF_NX,
    ST_TM0, ST_TM1, ST_TM2,
    ST_PS0, ST_PS1,
    ST_UN0, ST_UN1, ST_UN2, ST_UN3, ST_UNW0, ST_UNW1,
    ST_LI0, ST_LI1, ST_LI2, ST_LI3,
    ST_LNL_P, ST_LNL_CHK, ST_LNL_SZ, ST_LNL_NX, ST_LNL_END,
    ST_LI_B, ST_LI_B1
  } state_e;

endpackage

### hw/rtl/best_fit_pool_allocator.sv
// Best-fit pool allocator: sequencer plus the 4096 x 14 tag memory.
// Depends on bfpa_pkg for types, constants and sequencer states.
`timescale 1ns / 1ps

// One command (allocate or free) is taken at a time and answered with one
// result beat. All heap state lives in one single-port tag memory with a
// registered read. The sequencer makes at most one memory access per
// cycle, so a write is always visible to the next read. The cost of a
// command is set by the walks of the size-sorted free list: by the list
// nodes visited and by the fixed relinking per list insertion or removal.
// An insertion that finds no node at least as large walks the list a second
// time. An allocate takes one list walk for the fit and, on a split, two
// insertions; a free takes one insertion and one more per merged neighbour.
// A rejected handle is answered straight after the tag checks, before any
// list work. After reset and after each pool size write the block rewrites
// the initial block tags in ST_INIT0 to ST_INIT3 before it accepts a command.
module best_fit_pool_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bfpa_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bfpa_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfpa_pkg::NPOOL_W-1:0]  cfg_data_i
);

  function automatic bfpa_pkg::word_t abs_w(input bfpa_pkg::word_t v);
    abs_w = v[15] ? -v : v;
  endfunction

  // Tag memory
  logic [bfpa_pkg::TAG_W-1:0] mem_q [bfpa_pkg::POOL_DEPTH];
  logic [bfpa_pkg::TAG_W-1:0] rd_data_q;
  logic                       rd_ok_q;
  logic                       mem_re, mem_we;
  bfpa_pkg::word_t            mem_raddr, mem_waddr, mem_wdata;

  // Control state
  bfpa_pkg::state_e             state_q, state_d;
  logic [bfpa_pkg::NPOOL_W-1:0] npool_q, npool_d;
  logic [bfpa_pkg::ADDR_W-1:0]  head_q, head_d;
  logic                         out_valid_q, out_valid_d;

  // Command registers
  bfpa_pkg::word_t size_q, size_d, node_q, node_d, have_q, have_d;
  bfpa_pkg::word_t tag_q, tag_d, right_q, right_d, left_q, left_d;
  logic [1:0]                  status_q, status_d;
  logic [bfpa_pkg::ADDR_W-1:0] addr_q, addr_d;
  bfpa_pkg::out_t              out_q, out_d;

  // First-fit walk
  bfpa_pkg::word_t              ff_size_q, ff_size_d, ff_cur_q, ff_cur_d;
  logic [bfpa_pkg::NPOOL_W-1:0] ff_steps_q, ff_steps_d;
  bfpa_pkg::state_e             ff_ret_q, ff_ret_d;

  // Tag check
  bfpa_pkg::word_t  tm_b_q, tm_b_d, tm_v_q, tm_v_d, tm_size_q, tm_size_d;
  logic             tm_ok_q, tm_ok_d;
  bfpa_pkg::state_e tm_ret_q, tm_ret_d;

  // Tag write
  bfpa_pkg::word_t  ps_b_q, ps_b_d, ps_size_q, ps_size_d;
  logic             ps_free_q, ps_free_d;
  bfpa_pkg::state_e ps_ret_q, ps_ret_d;

  // Unlink
  bfpa_pkg::word_t  un_node_q, un_node_d, un_n_q, un_n_d, un_p_q, un_p_d;
  bfpa_pkg::state_e un_ret_q, un_ret_d;

  // Link in
  bfpa_pkg::word_t  li_node_q, li_node_d, li_size_q, li_size_d;
  bfpa_pkg::word_t  li_after_q, li_after_d, li_before_q, li_before_d;
  bfpa_pkg::word_t  li_cur_q, li_cur_d, li_prev_q, li_prev_d;
  logic [bfpa_pkg::NPOOL_W-1:0] li_steps_q, li_steps_d;
  bfpa_pkg::state_e li_ret_q, li_ret_d;

  // Merge
  bfpa_pkg::word_t  m_a_q, m_a_d, m_b_q, m_b_d, m_sa_q, m_sa_d, m_sb_q, m_sb_d;
  bfpa_pkg::state_e m_ret_q, m_ret_d;

  // Derived values
  bfpa_pkg::word_t rdv, rd_abs, npool_w, head_w, m_lo, m_sum, req_size;
  logic [bfpa_pkg::NPOOL_W:0] ff_steps_inc, li_steps_inc;
  logic ff_over, li_over, free_bad, in_acc, cfg_acc, out_free;

  assign rdv      = rd_ok_q ? {{2{rd_data_q[bfpa_pkg::TAG_W-1]}}, rd_data_q} : '0;
  assign rd_abs   = abs_w(rdv);
  assign npool_w  = $signed({3'b000, npool_q});
  assign head_w   = $signed({4'b0000, head_q});
  assign m_lo     = (m_a_q < m_b_q) ? m_a_q : m_b_q;
  assign m_sum    = m_sa_q + m_sb_q;
  assign req_size = $signed({3'b000, in_data_i.request_words}) + 16'sd2;
  assign ff_steps_inc = {1'b0, ff_steps_q} + 14'd1;
  assign li_steps_inc = {1'b0, li_steps_q} + 14'd1;
  assign ff_over  = ff_steps_inc > {1'b0, npool_q};
  assign li_over  = li_steps_inc > {1'b0, npool_q};
  assign free_bad = (node_q < 16'sd2) || (node_q >= npool_w) || !rdv[15] ||
                    (rd_abs < 16'(bfpa_pkg::OVERHEAD)) || (node_q + rd_abs > npool_w);

  assign in_stall_o  = (state_q != bfpa_pkg::ST_IDLE) | cfg_valid_i;
  assign cfg_ready_o = (state_q == bfpa_pkg::ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bfpa_pkg::ST_INIT0: state_d = bfpa_pkg::ST_INIT1;
      bfpa_pkg::ST_INIT1: state_d = bfpa_pkg::ST_INIT2;
      bfpa_pkg::ST_INIT2: state_d = bfpa_pkg::ST_INIT3;
      bfpa_pkg::ST_INIT3: state_d = bfpa_pkg::ST_IDLE;
      bfpa_pkg::ST_IDLE: begin
        if (cfg_acc) state_d = bfpa_pkg::ST_INIT0;
        else if (in_acc) begin
          state_d = (in_data_i.cmd == bfpa_pkg::CMD_ALLOC) ? bfpa_pkg::ST_A0
                                                           : bfpa_pkg::ST_F0;
        end
      end
      bfpa_pkg::ST_A0: state_d = bfpa_pkg::ST_FF0;
      bfpa_pkg::ST_A1: state_d = (ff_cur_q == 0) ? bfpa_pkg::ST_FIN0 : bfpa_pkg::ST_A2;
      bfpa_pkg::ST_A2: begin
        state_d = (rd_abs >= size_q + 16'(bfpa_pkg::OVERHEAD)) ? bfpa_pkg::ST_PS0
                                                                : bfpa_pkg::ST_A6;
      end
      bfpa_pkg::ST_A3:  state_d = bfpa_pkg::ST_PS0;
      bfpa_pkg::ST_A4:  state_d = bfpa_pkg::ST_UN0;
      bfpa_pkg::ST_A5:  state_d = bfpa_pkg::ST_LI0;
      bfpa_pkg::ST_A5B: state_d = bfpa_pkg::ST_LI0;
      bfpa_pkg::ST_A6:  state_d = bfpa_pkg::ST_A7;
      bfpa_pkg::ST_A7:  state_d = bfpa_pkg::ST_PS0;
      bfpa_pkg::ST_A8:  state_d = bfpa_pkg::ST_UN0;
      bfpa_pkg::ST_A9:  state_d = bfpa_pkg::ST_FIN0;
      bfpa_pkg::ST_F0:  state_d = bfpa_pkg::ST_F1;
      bfpa_pkg::ST_F1:  state_d = free_bad ? bfpa_pkg::ST_FIN0 : bfpa_pkg::ST_F2;
      bfpa_pkg::ST_F2: begin
        if (rdv != tag_q) state_d = bfpa_pkg::ST_FIN0;
        else state_d = (node_q > 16'sd2) ? bfpa_pkg::ST_F3 : bfpa_pkg::ST_F4;
      end
      bfpa_pkg::ST_F3: state_d = bfpa_pkg::ST_F4;
      bfpa_pkg::ST_F4: state_d = bfpa_pkg::ST_PS0;
      bfpa_pkg::ST_F5: state_d = bfpa_pkg::ST_LI0;
      bfpa_pkg::ST_F6: state_d = (right_q < npool_w) ? bfpa_pkg::ST_F7 : bfpa_pkg::ST_F8;
      bfpa_pkg::ST_F7: state_d = !rdv[15] ? bfpa_pkg::ST_M0 : bfpa_pkg::ST_F8;
      bfpa_pkg::ST_F8: begin
        state_d = (left_q >= 16'sd2 && left_q < node_q) ? bfpa_pkg::ST_F9
                                                         : bfpa_pkg::ST_FIN0;
      end
      bfpa_pkg::ST_F9: state_d = !rdv[15] ? bfpa_pkg::ST_M0 : bfpa_pkg::ST_FIN0;
      bfpa_pkg::ST_M0: state_d = bfpa_pkg::ST_TM0;
      bfpa_pkg::ST_M1: state_d = tm_ok_q ? bfpa_pkg::ST_TM0 : m_ret_q;
      bfpa_pkg::ST_M2: state_d = tm_ok_q ? bfpa_pkg::ST_UN0 : m_ret_q;
      bfpa_pkg::ST_M3: state_d = bfpa_pkg::ST_UN0;
      bfpa_pkg::ST_M4: state_d = bfpa_pkg::ST_PS0;
      bfpa_pkg::ST_M5: state_d = bfpa_pkg::ST_LI0;
      bfpa_pkg::ST_FIN0: state_d = bfpa_pkg::ST_FIN1;
      bfpa_pkg::ST_FIN1: if (out_free) state_d = bfpa_pkg::ST_IDLE;
      bfpa_pkg::ST_FF0:  state_d = bfpa_pkg::ST_FF_CHK;
      bfpa_pkg::ST_FF_CHK: state_d = (ff_cur_q == 0) ? ff_ret_q : bfpa_pkg::ST_FF_SZ;
      bfpa_pkg::ST_FF_SZ: begin
        if (rd_abs >= ff_size_q || ff_over) state_d = ff_ret_q;
        else state_d = bfpa_pkg::ST_FF_NX;
      end
      bfpa_pkg::ST_FF_NX: state_d = bfpa_pkg::ST_FF_CHK;
      bfpa_pkg::ST_TM0: state_d = bfpa_pkg::ST_TM1;
      bfpa_pkg::ST_TM1: state_d = bfpa_pkg::ST_TM2;
      bfpa_pkg::ST_TM2: state_d = tm_ret_q;
      bfpa_pkg::ST_PS0: begin
        state_d = (ps_size_q < 16'(bfpa_pkg::OVERHEAD)) ? ps_ret_q : bfpa_pkg::ST_PS1;
      end
      bfpa_pkg::ST_PS1: state_d = ps_ret_q;
      bfpa_pkg::ST_UN0: state_d = bfpa_pkg::ST_TM0;
      bfpa_pkg::ST_UN1: begin
        if (!tm_ok_q) state_d = un_ret_q;
        else state_d = (un_node_q == 0) ? bfpa_pkg::ST_UNW0 : bfpa_pkg::ST_UN2;
      end
      bfpa_pkg::ST_UN2:  state_d = bfpa_pkg::ST_UN3;
      bfpa_pkg::ST_UN3:  state_d = bfpa_pkg::ST_UNW0;
      bfpa_pkg::ST_UNW0: state_d = bfpa_pkg::ST_UNW1;
      bfpa_pkg::ST_UNW1: state_d = un_ret_q;
      bfpa_pkg::ST_LI0:  state_d = bfpa_pkg::ST_FF0;
      bfpa_pkg::ST_LI1: begin
        if (ff_cur_q != 0) state_d = bfpa_pkg::ST_LI2;
        else state_d = (head_q == '0) ? bfpa_pkg::ST_LNL_CHK : bfpa_pkg::ST_LNL_P;
      end
      bfpa_pkg::ST_LI2:   state_d = bfpa_pkg::ST_LI3;
      bfpa_pkg::ST_LI3:   state_d = bfpa_pkg::ST_LI_B;
      bfpa_pkg::ST_LNL_P: state_d = bfpa_pkg::ST_LNL_CHK;
      bfpa_pkg::ST_LNL_CHK: begin
        state_d = (li_cur_q == 0) ? bfpa_pkg::ST_LNL_END : bfpa_pkg::ST_LNL_SZ;
      end
      bfpa_pkg::ST_LNL_SZ: begin
        if (rd_abs <= li_size_q && !li_over) state_d = bfpa_pkg::ST_LNL_NX;
        else state_d = bfpa_pkg::ST_LNL_END;
      end
      bfpa_pkg::ST_LNL_NX:  state_d = bfpa_pkg::ST_LNL_CHK;
      bfpa_pkg::ST_LNL_END: state_d = bfpa_pkg::ST_LI_B;
      bfpa_pkg::ST_LI_B:  state_d = (li_before_q == 0) ? li_ret_q : bfpa_pkg::ST_LI_B1;
      bfpa_pkg::ST_LI_B1: state_d = li_ret_q;
      default: state_d = bfpa_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    npool_d = npool_q;  head_d = head_q;  out_valid_d = out_valid_q & out_stall_i;
    size_d = size_q;  node_d = node_q;  have_d = have_q;  tag_d = tag_q;
    right_d = right_q;  left_d = left_q;  status_d = status_q;  addr_d = addr_q;
    out_d = out_q;
    ff_size_d = ff_size_q;  ff_cur_d = ff_cur_q;  ff_steps_d = ff_steps_q;
    ff_ret_d = ff_ret_q;
    tm_b_d = tm_b_q;  tm_v_d = tm_v_q;  tm_size_d = tm_size_q;  tm_ok_d = tm_ok_q;
    tm_ret_d = tm_ret_q;
    ps_b_d = ps_b_q;  ps_size_d = ps_size_q;  ps_free_d = ps_free_q;
    ps_ret_d = ps_ret_q;
    un_node_d = un_node_q;  un_n_d = un_n_q;  un_p_d = un_p_q;  un_ret_d = un_ret_q;
    li_node_d = li_node_q;  li_size_d = li_size_q;  li_after_d = li_after_q;
    li_before_d = li_before_q;  li_cur_d = li_cur_q;  li_prev_d = li_prev_q;
    li_steps_d = li_steps_q;  li_ret_d = li_ret_q;
    m_a_d = m_a_q;  m_b_d = m_b_q;  m_sa_d = m_sa_q;  m_sb_d = m_sb_q;
    m_ret_d = m_ret_q;
    mem_re = 1'b0;  mem_raddr = '0;  mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;

    case (state_q)
      // Rewrite the initial single free block
      bfpa_pkg::ST_INIT0: begin
        mem_we = 1'b1;  mem_waddr = 16'sd2;  mem_wdata = npool_w - 16'sd2;
      end
      bfpa_pkg::ST_INIT1: begin
        mem_we = 1'b1;  mem_waddr = npool_w - 16'sd1;  mem_wdata = npool_w - 16'sd2;
      end
      bfpa_pkg::ST_INIT2: begin
        mem_we = 1'b1;  mem_waddr = 16'sd3;
      end
      bfpa_pkg::ST_INIT3: begin
        mem_we = 1'b1;  mem_waddr = 16'sd4;  head_d = bfpa_pkg::FIRST_BLK;
      end
      // Take a register write or a command beat
      bfpa_pkg::ST_IDLE: begin
        if (cfg_acc) begin
          if (cfg_data_i < bfpa_pkg::MIN_POOL) npool_d = bfpa_pkg::MIN_POOL;
          else if (cfg_data_i > bfpa_pkg::MAX_POOL) npool_d = bfpa_pkg::MAX_POOL;
          else npool_d = cfg_data_i;
        end else if (in_acc) begin
          status_d = bfpa_pkg::STATUS_OK;
          addr_d   = '0;
          size_d   = (req_size < 16'(bfpa_pkg::OVERHEAD)) ? 16'(bfpa_pkg::OVERHEAD)
                                                          : req_size;
          node_d   = $signed({4'b0000, in_data_i.handle}) - 16'sd1;
        end
      end
      // Allocate
      bfpa_pkg::ST_A0: begin
        ff_size_d = size_q;  ff_ret_d = bfpa_pkg::ST_A1;
      end
      bfpa_pkg::ST_A1: begin
        if (ff_cur_q == 0) status_d = bfpa_pkg::STATUS_NO_FIT;
        else begin
          node_d = ff_cur_q;  mem_re = 1'b1;  mem_raddr = ff_cur_q;
        end
      end
      bfpa_pkg::ST_A2: begin
        have_d = rd_abs;
        ps_b_d = node_q + size_q;  ps_size_d = rd_abs - size_q;  ps_free_d = 1'b1;
        ps_ret_d = bfpa_pkg::ST_A3;
      end
      bfpa_pkg::ST_A3: begin
        ps_b_d = node_q;  ps_size_d = size_q;  ps_free_d = 1'b1;
        ps_ret_d = bfpa_pkg::ST_A4;
      end
      bfpa_pkg::ST_A4: begin
        un_node_d = node_q;  un_ret_d = bfpa_pkg::ST_A5;
      end
      bfpa_pkg::ST_A5: begin
        li_node_d = node_q + size_q;  li_size_d = have_q - size_q;
        li_ret_d = bfpa_pkg::ST_A5B;
      end
      bfpa_pkg::ST_A5B: begin
        li_node_d = node_q;  li_size_d = size_q;  li_ret_d = bfpa_pkg::ST_A6;
      end
      bfpa_pkg::ST_A6: begin
        mem_re = 1'b1;  mem_raddr = node_q;
      end
      bfpa_pkg::ST_A7: begin
        ps_b_d = node_q;  ps_size_d = rd_abs;  ps_free_d = 1'b0;
        ps_ret_d = bfpa_pkg::ST_A8;
      end
      bfpa_pkg::ST_A8: begin
        un_node_d = node_q;  un_ret_d = bfpa_pkg::ST_A9;
      end
      bfpa_pkg::ST_A9: addr_d = node_q[bfpa_pkg::ADDR_W-1:0] + 12'd1;
      // Free: check the handle, then relink and merge
      bfpa_pkg::ST_F0: begin
        mem_re = 1'b1;  mem_raddr = node_q;
      end
      bfpa_pkg::ST_F1: begin
        tag_d = rdv;  size_d = rd_abs;
        if (free_bad) status_d = bfpa_pkg::STATUS_BAD_HANDLE;
        else begin
          mem_re = 1'b1;  mem_raddr = node_q + rd_abs - 16'sd1;
        end
      end
      bfpa_pkg::ST_F2: begin
        right_d = node_q + size_q;
        left_d  = -16'sd1;
        if (rdv != tag_q) status_d = bfpa_pkg::STATUS_BAD_HANDLE;
        else if (node_q > 16'sd2) begin
          mem_re = 1'b1;  mem_raddr = node_q - 16'sd1;
        end
      end
      bfpa_pkg::ST_F3: left_d = node_q - rd_abs;
      bfpa_pkg::ST_F4: begin
        ps_b_d = node_q;  ps_size_d = size_q;  ps_free_d = 1'b1;
        ps_ret_d = bfpa_pkg::ST_F5;
      end
      bfpa_pkg::ST_F5: begin
        li_node_d = node_q;  li_size_d = size_q;  li_ret_d = bfpa_pkg::ST_F6;
      end
      bfpa_pkg::ST_F6: begin
        mem_re = (right_q < npool_w);  mem_raddr = right_q;
      end
      bfpa_pkg::ST_F7: begin
        m_a_d = node_q;  m_b_d = right_q;  m_ret_d = bfpa_pkg::ST_F8;
      end
      bfpa_pkg::ST_F8: begin
        mem_re = (left_q >= 16'sd2 && left_q < node_q);  mem_raddr = left_q;
      end
      bfpa_pkg::ST_F9: begin
        m_a_d = node_q;  m_b_d = left_q;  m_ret_d = bfpa_pkg::ST_FIN0;
      end
      // Merge two free blocks
      bfpa_pkg::ST_M0: begin
        tm_b_d = m_a_q;  tm_ret_d = bfpa_pkg::ST_M1;
      end
      bfpa_pkg::ST_M1: begin
        m_sa_d = tm_size_q;  tm_b_d = m_b_q;  tm_ret_d = bfpa_pkg::ST_M2;
      end
      bfpa_pkg::ST_M2: begin
        m_sb_d = tm_size_q;  un_node_d = m_b_q;  un_ret_d = bfpa_pkg::ST_M3;
      end
      bfpa_pkg::ST_M3: begin
        un_node_d = m_a_q;  un_ret_d = bfpa_pkg::ST_M4;
      end
      bfpa_pkg::ST_M4: begin
        ps_b_d = m_lo;  ps_size_d = m_sum;  ps_free_d = 1'b1;
        ps_ret_d = bfpa_pkg::ST_M5;
      end
      bfpa_pkg::ST_M5: begin
        li_node_d = m_lo;  li_size_d = m_sum;  li_ret_d = m_ret_q;
      end
      // Read word 2 for the all-free flag, then hand off the result beat
      bfpa_pkg::ST_FIN0: begin
        mem_re = 1'b1;  mem_raddr = 16'sd2;
      end
      bfpa_pkg::ST_FIN1: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.status     = status_q;
          out_d.address    = addr_q;
          out_d.all_free   = (head_q == bfpa_pkg::FIRST_BLK) &&
                             (rdv == npool_w - 16'sd2);
        end
      end
      // First block at least ff_size words long
      bfpa_pkg::ST_FF0: begin
        ff_cur_d = head_w;  ff_steps_d = '0;
      end
      bfpa_pkg::ST_FF_CHK: begin
        mem_re = (ff_cur_q != 0);  mem_raddr = ff_cur_q;
      end
      bfpa_pkg::ST_FF_SZ: begin
        if (rd_abs < ff_size_q) begin
          if (ff_over) ff_cur_d = '0;
          else begin
            ff_steps_d = ff_steps_inc[bfpa_pkg::NPOOL_W-1:0];
            mem_re = 1'b1;  mem_raddr = ff_cur_q + 16'sd1;
          end
        end
      end
      bfpa_pkg::ST_FF_NX: ff_cur_d = (rdv == ff_cur_q) ? '0 : rdv;
      // Compare header and footer
      bfpa_pkg::ST_TM0: begin
        mem_re = 1'b1;  mem_raddr = tm_b_q;
      end
      bfpa_pkg::ST_TM1: begin
        tm_v_d = rdv;  mem_re = 1'b1;  mem_raddr = tm_b_q + rd_abs - 16'sd1;
      end
      bfpa_pkg::ST_TM2: begin
        tm_ok_d = (tm_v_q == rdv);  tm_size_d = abs_w(tm_v_q);
      end
      // Write header and footer
      bfpa_pkg::ST_PS0: begin
        mem_we = (ps_size_q >= 16'(bfpa_pkg::OVERHEAD));  mem_waddr = ps_b_q;
        mem_wdata = ps_free_q ? ps_size_q : -ps_size_q;
      end
      bfpa_pkg::ST_PS1: begin
        mem_we = 1'b1;  mem_waddr = ps_b_q + ps_size_q - 16'sd1;
        mem_wdata = ps_free_q ? ps_size_q : -ps_size_q;
      end
      // Drop a node from the free list
      bfpa_pkg::ST_UN0: begin
        tm_b_d = un_node_q;  tm_ret_d = bfpa_pkg::ST_UN1;
      end
      bfpa_pkg::ST_UN1: begin
        un_n_d = head_w;  un_p_d = '0;
        mem_re = tm_ok_q && (un_node_q != 0);  mem_raddr = un_node_q + 16'sd1;
      end
      bfpa_pkg::ST_UN2: begin
        un_n_d = (rdv == un_node_q) ? '0 : rdv;
        mem_re = 1'b1;  mem_raddr = un_node_q + 16'sd2;
      end
      bfpa_pkg::ST_UN3: un_p_d = (rdv == un_node_q) ? '0 : rdv;
      bfpa_pkg::ST_UNW0: begin
        mem_we = (un_p_q != 0);  mem_waddr = un_p_q + 16'sd1;  mem_wdata = un_n_q;
      end
      bfpa_pkg::ST_UNW1: begin
        mem_we = (un_n_q != 0);  mem_waddr = un_n_q + 16'sd2;  mem_wdata = un_p_q;
        if (un_node_q == head_w) head_d = un_n_q[bfpa_pkg::ADDR_W-1:0];
      end
      // Insert a node in front of the first one at least as large
      bfpa_pkg::ST_LI0: begin
        ff_size_d = li_size_q;  ff_ret_d = bfpa_pkg::ST_LI1;
      end
      bfpa_pkg::ST_LI1: begin
        li_after_d = ff_cur_q;
        li_cur_d   = head_w;
        li_steps_d = '0;
        li_prev_d  = '0;
        mem_re     = 1'b1;
        mem_raddr  = (ff_cur_q != 0) ? ff_cur_q + 16'sd2 : head_w + 16'sd2;
        if (ff_cur_q == 0 && head_q == '0) mem_re = 1'b0;
      end
      bfpa_pkg::ST_LI2: begin
        li_before_d = (rdv == li_after_q) ? '0 : rdv;
        mem_we = 1'b1;  mem_waddr = li_after_q + 16'sd2;  mem_wdata = li_node_q;
      end
      bfpa_pkg::ST_LI3: begin
        mem_we = (li_node_q != 0);  mem_waddr = li_node_q + 16'sd1;
        mem_wdata = li_after_q;
      end
      bfpa_pkg::ST_LNL_P: li_prev_d = (rdv == li_cur_q) ? '0 : rdv;
      bfpa_pkg::ST_LNL_CHK: begin
        mem_re = (li_cur_q != 0);  mem_raddr = li_cur_q;
      end
      bfpa_pkg::ST_LNL_SZ: begin
        if (rd_abs <= li_size_q && !li_over) begin
          li_steps_d = li_steps_inc[bfpa_pkg::NPOOL_W-1:0];
          li_prev_d  = li_cur_q;
          mem_re = 1'b1;  mem_raddr = li_cur_q + 16'sd1;
        end
      end
      bfpa_pkg::ST_LNL_NX: li_cur_d = (rdv == li_cur_q) ? '0 : rdv;
      bfpa_pkg::ST_LNL_END: begin
        li_before_d = li_prev_q;
        mem_we = (li_node_q != 0);  mem_waddr = li_node_q + 16'sd1;
      end
      bfpa_pkg::ST_LI_B: begin
        if (li_before_q == 0) begin
          head_d = li_node_q[bfpa_pkg::ADDR_W-1:0];
          mem_we = (li_node_q != 0);  mem_waddr = li_node_q + 16'sd2;
        end else begin
          mem_we = 1'b1;  mem_waddr = li_before_q + 16'sd1;  mem_wdata = li_node_q;
        end
      end
      bfpa_pkg::ST_LI_B1: begin
        mem_we = (li_node_q != 0);  mem_waddr = li_node_q + 16'sd2;
        mem_wdata = li_before_q;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Tag memory: one access a cycle, out-of-pool writes dropped, reads masked
  always_ff @(posedge clk_i) begin
    if (mem_we && mem_waddr >= 0 && mem_waddr < npool_w) begin
      mem_q[mem_waddr[bfpa_pkg::ADDR_W-1:0]] <= mem_wdata[bfpa_pkg::TAG_W-1:0];
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr[bfpa_pkg::ADDR_W-1:0]];
      rd_ok_q   <= (mem_raddr >= 0) && (mem_raddr < npool_w);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfpa_pkg::ST_INIT0;
      npool_q     <= bfpa_pkg::MAX_POOL;
      head_q      <= bfpa_pkg::FIRST_BLK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      npool_q     <= npool_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    size_q <= size_d;  node_q <= node_d;  have_q <= have_d;  tag_q <= tag_d;
    right_q <= right_d;  left_q <= left_d;  status_q <= status_d;
    addr_q <= addr_d;  out_q <= out_d;
    ff_size_q <= ff_size_d;  ff_cur_q <= ff_cur_d;  ff_steps_q <= ff_steps_d;
    ff_ret_q <= ff_ret_d;
    tm_b_q <= tm_b_d;  tm_v_q <= tm_v_d;  tm_size_q <= tm_size_d;
    tm_ok_q <= tm_ok_d;  tm_ret_q <= tm_ret_d;
    ps_b_q <= ps_b_d;  ps_size_q <= ps_size_d;  ps_free_q <= ps_free_d;
    ps_ret_q <= ps_ret_d;
    un_node_q <= un_node_d;  un_n_q <= un_n_d;  un_p_q <= un_p_d;
    un_ret_q <= un_ret_d;
    li_node_q <= li_node_d;  li_size_q <= li_size_d;  li_after_q <= li_after_d;
    li_before_q <= li_before_d;  li_cur_q <= li_cur_d;  li_prev_q <= li_prev_d;
    li_steps_q <= li_steps_d;  li_ret_q <= li_ret_d;
    m_a_q <= m_a_d;  m_b_q <= m_b_d;  m_sa_q <= m_sa_d;  m_sb_q <= m_sb_d;
    m_ret_q <= m_ret_d;
  end

`ifndef SYNTHESIS
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_re && mem_we))
    else $error("tag memory read and written in one cycle");

  a_npool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    npool_q >= bfpa_pkg::MIN_POOL && npool_q <= bfpa_pkg::MAX_POOL)
    else $error("pool size out of range");

  a_init_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfpa_pkg::ST_INIT3 |=> head_q == bfpa_pkg::FIRST_BLK)
    else $error("list head not restored by init");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == bfpa_pkg::ST_FIN1))
    else $error("result beat raised outside the finish step");
`endif

endmodule
